>>> rtl/lt_kmerge_pkg.sv
// Shared types and constants for the loser tree k-way merge engine.
package lt_kmerge_pkg;

  localparam int KEY_W     = 31;
  localparam int WAY_FW    = 3;
  localparam int SLOT_FW   = 3;
  localparam int WAY_IX_W  = 6;
  localparam int PTR_IX_W  = 11;

  typedef logic [KEY_W-1:0]    key_t;
  typedef logic [WAY_IX_W-1:0] way_ix_t;
  typedef logic [PTR_IX_W-1:0] ptr_ix_t;

  localparam key_t SENTINEL = {KEY_W{1'b1}};

  localparam logic [1:0] KIND_LOAD  = 2'd0;
  localparam logic [1:0] KIND_BUILD = 2'd1;
  localparam logic [1:0] KIND_POP   = 2'd2;

  typedef struct packed {
    logic [1:0]         kind;
    logic [WAY_FW-1:0]  way;
    logic [SLOT_FW-1:0] slot;
    key_t               key;
  } in_item_t;

  typedef struct packed {
    key_t              winner_key;
    logic [WAY_FW-1:0] winner_way;
  } out_item_t;

  typedef struct packed {
    logic    rd_en;
    way_ix_t rd_way;
    ptr_ix_t rd_ptr;
    logic    wr_en;
    way_ix_t wr_way;
    ptr_ix_t wr_slot;
    key_t    wr_key;
  } store_req_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_WIN,
    ST_EMIT,
    ST_START,
    ST_CUR,
    ST_LVL,
    ST_CMP
  } state_e;

endpackage

>>> rtl/lt_kmerge_stream_if.sv
// Valid/ready stream interface carrying one payload word.
interface lt_kmerge_stream_if #(
  parameter type T = logic
) ();
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

>>> rtl/lt_kmerge_store.sv
// Key buffer memory with registered head read and post-reset clearing pass.
module lt_kmerge_store import lt_kmerge_pkg::*; #(
  parameter int WAYS      = 8,
  parameter int WAY_DEPTH = 8
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  store_req_t req_i,
  output key_t       head_o,
  output logic       busy_o
);
  localparam int DEPTH  = WAYS * WAY_DEPTH;
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  key_t              mem_q [DEPTH];
  key_t              rd_q;
  logic              sent_q;
  logic              busy_q;
  logic [ADDR_W-1:0] clr_q, clr_d;
  logic [ADDR_W-1:0] rd_addr, wr_addr;
  logic              rd_sent, wr_ok;

  always_comb begin
    rd_sent = 32'(req_i.rd_ptr) >= 32'(WAY_DEPTH);
    rd_addr = rd_sent ? '0 :
              ADDR_W'(32'(req_i.rd_way) * 32'(WAY_DEPTH) + 32'(req_i.rd_ptr));
    wr_ok   = req_i.wr_en && (32'(req_i.wr_way) < 32'(WAYS)) &&
              (32'(req_i.wr_slot) < 32'(WAY_DEPTH));
    wr_addr = ADDR_W'(32'(req_i.wr_way) * 32'(WAY_DEPTH) + 32'(req_i.wr_slot));
    clr_d   = clr_q + ADDR_W'(1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b1;
      clr_q  <= '0;
    end else if (busy_q) begin
      clr_q <= clr_d;
      if (clr_q == ADDR_W'(DEPTH - 1)) begin
        busy_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (busy_q) begin
      mem_q[clr_q] <= SENTINEL;
    end else if (wr_ok) begin
      mem_q[wr_addr] <= req_i.wr_key;
    end
    if (req_i.rd_en) begin
      rd_q   <= mem_q[rd_addr];
      sent_q <= rd_sent;
    end
  end

  assign head_o = sent_q ? SENTINEL : rd_q;
  assign busy_o = busy_q;

endmodule

>>> rtl/lt_kmerge_ctrl.sv
// Sequencer, loser nodes, read pointers and the shared key comparator.
module lt_kmerge_ctrl import lt_kmerge_pkg::*; #(
  parameter int WAYS      = 8,
  parameter int WAY_DEPTH = 8
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  input  in_item_t   in_item_i,
  output logic       in_ready_o,
  output store_req_t req_o,
  input  key_t       head_i,
  input  logic       store_busy_i,
  output logic       res_valid_o,
  output out_item_t  res_o,
  input  logic       res_ready_i
);
  localparam int WAY_W = $clog2(WAYS);
  localparam int PTR_W = $clog2(WAY_DEPTH + 1);

  typedef struct packed {
    logic             vld;
    logic [WAY_W-1:0] way;
  } node_t;

  state_e            state_q, state_d;
  node_t             node_q [WAYS];
  logic [PTR_W-1:0]  ptr_q [WAYS];
  logic [WAY_W-1:0]  cur_q, p_q, bw_q;
  logic              build_q, climb_q;
  key_t              cur_key_q, res_key_q;
  logic [WAY_FW-1:0] res_way_q;

  logic             accept, gt, more;
  node_t            node_n;
  logic [WAY_W-1:0] rd_way, leaf_p;
  logic [WAY_W:0]   leaf_sum;

  always_comb begin
    accept   = in_valid_i && in_ready_o;
    node_n   = node_q[p_q];
    gt       = cur_key_q > head_i;
    more     = build_q && (bw_q != '0);
    leaf_sum = (WAY_W+1)'(cur_q) + (WAY_W+1)'(WAYS);
    leaf_p   = leaf_sum[WAY_W:1];
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          case (in_item_i.kind)
            KIND_BUILD: state_d = ST_START;
            KIND_POP:   state_d = node_q[0].vld ? ST_WIN : ST_EMIT;
            default:    state_d = ST_IDLE;
          endcase
        end
      end
      ST_WIN:   state_d = ST_EMIT;
      ST_EMIT: begin
        if (res_ready_i) begin
          state_d = climb_q ? ST_START : ST_IDLE;
        end
      end
      ST_START: state_d = ST_CUR;
      ST_CUR:   state_d = ST_LVL;
      ST_LVL: begin
        if (!node_n.vld) begin
          state_d = more ? ST_START : ST_IDLE;
        end else begin
          state_d = ST_CMP;
        end
      end
      ST_CMP: begin
        if (p_q == '0) begin
          state_d = more ? ST_START : ST_IDLE;
        end else begin
          state_d = ST_LVL;
        end
      end
      default:  state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready_o    = (state_q == ST_IDLE) && !store_busy_i;
    res_valid_o   = (state_q == ST_EMIT);
    res_o         = '{winner_key: res_key_q, winner_way: res_way_q};
    req_o         = '0;
    case (state_q)
      ST_IDLE: rd_way = node_q[0].way;
      ST_LVL:  rd_way = node_n.way;
      default: rd_way = cur_q;
    endcase
    req_o.rd_way  = WAY_IX_W'(rd_way);
    req_o.rd_ptr  = PTR_IX_W'(ptr_q[rd_way]);
    req_o.rd_en   = (accept && (in_item_i.kind == KIND_POP) && node_q[0].vld) ||
                    (state_q == ST_START) || ((state_q == ST_LVL) && node_n.vld);
    req_o.wr_en   = accept && (in_item_i.kind == KIND_LOAD);
    req_o.wr_way  = WAY_IX_W'(in_item_i.way);
    req_o.wr_slot = PTR_IX_W'(in_item_i.slot);
    req_o.wr_key  = in_item_i.key;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      for (int i = 0; i < WAYS; i++) begin
        node_q[i] <= '0;
        ptr_q[i]  <= '0;
      end
      cur_q   <= '0;
      p_q     <= '0;
      bw_q    <= '0;
      build_q <= 1'b0;
      climb_q <= 1'b0;
    end else begin
      state_q <= state_d;
      case (state_q)
        ST_IDLE: begin
          if (accept && (in_item_i.kind == KIND_BUILD)) begin
            for (int i = 0; i < WAYS; i++) begin
              node_q[i].vld <= 1'b0;
              ptr_q[i]      <= '0;
            end
            bw_q    <= WAY_W'(WAYS - 1);
            cur_q   <= WAY_W'(WAYS - 1);
            build_q <= 1'b1;
            climb_q <= 1'b0;
          end else if (accept && (in_item_i.kind == KIND_POP)) begin
            build_q <= 1'b0;
            climb_q <= node_q[0].vld;
            cur_q   <= node_q[0].way;
          end
        end
        ST_EMIT: begin
          if (res_ready_i && climb_q) begin
            node_q[0].vld <= 1'b0;
            if (ptr_q[cur_q] != PTR_W'(WAY_DEPTH)) begin
              ptr_q[cur_q] <= ptr_q[cur_q] + PTR_W'(1);
            end
          end
        end
        ST_START: p_q <= leaf_p;
        ST_LVL: begin
          if (!node_n.vld) begin
            node_q[p_q] <= '{vld: 1'b1, way: cur_q};
            if (more) begin
              bw_q  <= bw_q - WAY_W'(1);
              cur_q <= bw_q - WAY_W'(1);
            end
          end
        end
        ST_CMP: begin
          if (p_q == '0) begin
            if (more) begin
              bw_q  <= bw_q - WAY_W'(1);
              cur_q <= bw_q - WAY_W'(1);
            end else if (gt) begin
              cur_q <= node_n.way;
            end
          end else begin
            p_q <= p_q >> 1;
            if (gt) begin
              cur_q <= node_n.way;
            end
          end
          if (gt) begin
            node_q[p_q].way <= cur_q;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      ST_IDLE: begin
        if (accept && (in_item_i.kind == KIND_POP) && !node_q[0].vld) begin
          res_key_q <= SENTINEL;
          res_way_q <= '0;
        end
      end
      ST_WIN: begin
        res_key_q <= head_i;
        res_way_q <= WAY_FW'(cur_q);
      end
      ST_CUR:  cur_key_q <= head_i;
      ST_CMP: begin
        if (gt) begin
          cur_key_q <= head_i;
        end
      end
      default: ;
    endcase
  end

endmodule

>>> rtl/loser_tree_kway_merge.sv
// Top level of the loser tree k-way merge engine.
//   channel  dir  payload                      word accepted when
//   in_i     in   kind, way, slot, key         in_i.valid && in_i.ready
//   out_o    out  winner_key, winner_way       out_o.valid && out_o.ready
// Pop and build both make one key read and one compare per tree level
// through the shared comparator and the single read port of the buffers.
// After reset a clearing pass fills all WAYS*WAY_DEPTH buffer entries
// with the sentinel; no word is accepted meanwhile.
// A pop waits with its result while the output register is full and not being drained.
module loser_tree_kway_merge import lt_kmerge_pkg::*; #(
  parameter int WAYS      = 8,
  parameter int WAY_DEPTH = 8
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  lt_kmerge_stream_if.sink    in_i,
  lt_kmerge_stream_if.source  out_o
);
  store_req_t req;
  key_t       head;
  logic       store_busy;
  logic       in_ready;
  logic       res_valid, res_ready, res_push;
  out_item_t  res;
  out_item_t  out_q;
  logic       out_vld_q;

  lt_kmerge_store #(
    .WAYS      (WAYS),
    .WAY_DEPTH (WAY_DEPTH)
  ) u_store (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req),
    .head_o (head),
    .busy_o (store_busy)
  );

  lt_kmerge_ctrl #(
    .WAYS      (WAYS),
    .WAY_DEPTH (WAY_DEPTH)
  ) u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_i.valid),
    .in_item_i    (in_i.data),
    .in_ready_o   (in_ready),
    .req_o        (req),
    .head_i       (head),
    .store_busy_i (store_busy),
    .res_valid_o  (res_valid),
    .res_o        (res),
    .res_ready_i  (res_ready)
  );

  assign res_ready = !out_vld_q || out_o.ready;
  assign res_push  = res_valid && res_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (res_push) begin
      out_vld_q <= 1'b1;
    end else if (out_o.ready) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_push) begin
      out_q <= res;
    end
  end

  assign in_i.ready  = in_ready;
  assign out_o.valid = out_vld_q;
  assign out_o.data  = out_q;

`ifndef NO_ASSERTIONS
  a_busy_no_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    store_busy |-> !in_ready)
    else $error("word accepted during clearing pass");

  a_pop_blocks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_i.valid && in_ready && (in_i.data.kind == KIND_POP)) |=> !in_ready)
    else $error("ready held across a pop");

  a_push_fills: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_push |=> out_vld_q)
    else $error("result pushed but output register empty");
`endif

endmodule
